// ===== rtl/core/m2q_pkg.sv =====
`timescale 1ns / 1ps
package m2q_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 19;
  localparam int ACC_W     = FIELD_W + 2;          // trace and root argument, signed
  localparam int NUM_W     = FIELD_W + 1;          // numerator magnitude
  localparam int ARG_W     = FIELD_W + 1;          // positive root argument
  localparam int RAD_W     = ARG_W + FRAC_BITS;    // radicand
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_W      = RAD_W + 2;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int DIVD_W    = NUM_W + FRAC_BITS + 1;
  localparam int Q_W       = FIELD_W + 1;
  localparam int DV_W      = DEN_W + Q_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< FRAC_BITS;
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  // Output slot that receives the root term.
  typedef enum logic [1:0] {
    LEAD_X = 2'd0,
    LEAD_Y = 2'd1,
    LEAD_Z = 2'd2,
    LEAD_W = 2'd3
  } lead_e;

  typedef struct packed {
    logic                        bad;
    lead_e                       lead;
    logic [ARG_W-1:0]            arg;
    logic [2:0]                  neg;
    logic [2:0][NUM_W-1:0]       mag;
  } item_t;

endpackage

// ===== rtl/core/m2q_front.sv =====
`timescale 1ns / 1ps
module m2q_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e00_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e01_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e02_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e10_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e11_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e12_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e20_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e21_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e22_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e33_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output m2q_pkg::item_t                      item_o
);
  import m2q_pkg::*;

  logic signed [ACC_W-1:0] d0, d1, d2, tr, arg;
  logic signed [NUM_W-1:0] n0, n1, n2;
  logic [1:0]              axis;
  item_t                   item_d, item_q;
  logic                    valid_q;

  function automatic logic signed [NUM_W-1:0] add2(logic signed [FIELD_W-1:0] a,
                                                    logic signed [FIELD_W-1:0] b,
                                                    logic sub);
    logic signed [NUM_W-1:0] r;
    r = sub ? NUM_W'(a) - NUM_W'(b) : NUM_W'(a) + NUM_W'(b);
    return r;
  endfunction

  always_comb begin
    d0 = ACC_W'(e00_i);
    d1 = ACC_W'(e11_i);
    d2 = ACC_W'(e22_i);
    tr = d0 + d1 + d2 + ACC_W'(e33_i);
    axis = 2'd0;
    if (d0 <= d1) axis = 2'd1;
    if (axis == 2'd1) begin
      if (d2 > d1) axis = 2'd2;
    end else begin
      if (d2 > d0) axis = 2'd2;
    end
    if (tr >= ONE) begin
      item_d.lead = LEAD_W;
      arg = tr;
      n0 = add2(e12_i, e21_i, 1'b1);
      n1 = add2(e20_i, e02_i, 1'b1);
      n2 = add2(e01_i, e10_i, 1'b1);
    end else begin
      unique case (axis)
        2'd0: begin
          item_d.lead = LEAD_X;
          arg = d0 - d1 - d2 + ONE;
          n0 = add2(e10_i, e01_i, 1'b0);
          n1 = add2(e20_i, e02_i, 1'b0);
          n2 = add2(e12_i, e21_i, 1'b1);
        end
        2'd1: begin
          item_d.lead = LEAD_Y;
          arg = d1 - d2 - d0 + ONE;
          n0 = add2(e01_i, e10_i, 1'b0);
          n1 = add2(e21_i, e12_i, 1'b0);
          n2 = add2(e20_i, e02_i, 1'b1);
        end
        default: begin
          item_d.lead = LEAD_Z;
          arg = d2 - d0 - d1 + ONE;
          n0 = add2(e02_i, e20_i, 1'b0);
          n1 = add2(e12_i, e21_i, 1'b0);
          n2 = add2(e01_i, e10_i, 1'b1);
        end
      endcase
    end
    item_d.bad = (arg <= 0);
    // A bad item still runs through the datapath with a harmless argument.
    item_d.arg = item_d.bad ? ARG_W'(1) : arg[ARG_W-1:0];
    item_d.neg = {n2[NUM_W-1], n1[NUM_W-1], n0[NUM_W-1]};
    item_d.mag[0] = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
    item_d.mag[1] = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    item_d.mag[2] = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/m2q_fifo.sv =====
`timescale 1ns / 1ps
module m2q_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  m2q_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output m2q_pkg::item_t item_o
);
  import m2q_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               push, pop;

  assign ready_o = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== rtl/core/m2q_back.sv =====
`timescale 1ns / 1ps
module m2q_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  m2q_pkg::item_t                      item_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_x_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_y_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_z_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_w_o,
  output logic                                bad_input_o
);
  import m2q_pkg::*;

  typedef struct packed {
    logic                  bad;
    lead_e                 lead;
    logic [2:0]            neg;
    logic [2:0][NUM_W-1:0] mag;
  } side_t;

  logic en;

  // Square root: one result bit per stage.
  logic [ROOT_W:0]   sq_v;
  side_t             sq_side [ROOT_W+1];
  logic [SQ_W-1:0]   sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];

  // Division: setup stage then one quotient bit per stage.
  logic [Q_W:0]           dv_v;
  side_t                  dv_side [Q_W+1];
  logic [ROOT_W-1:0]      dv_root [Q_W+1];
  logic [2:0]             dv_ovf  [Q_W+1];
  logic [2:0][DIVD_W-1:0] dv_rem  [Q_W+1];
  logic [2:0][Q_W-1:0]    dv_quo  [Q_W+1];

  logic                      out_v_q, out_bad_q;
  logic signed [FIELD_W-1:0] out_x_q, out_y_q, out_z_q, out_w_q;

  assign en      = !out_v_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side[0] <= '{bad: item_i.bad, lead: item_i.lead, neg: item_i.neg, mag: item_i.mag};
      sq_rem[0]  <= SQ_W'({item_i.arg, {FRAC_BITS{1'b0}}});
      sq_root[0] <= '0;
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_sq
    localparam int B = ROOT_W - 1 - s;
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = (SQ_W'(sq_root[s]) << (B + 1)) + (SQ_W'(1) << (2 * B));
    assign take  = sq_rem[s] >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[s+1] <= 1'b0;
      end else if (en) begin
        sq_v[s+1] <= sq_v[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_side[s+1] <= sq_side[s];
        sq_rem[s+1]  <= take ? sq_rem[s] - trial : sq_rem[s];
        sq_root[s+1] <= take ? sq_root[s] | (ROOT_W'(1) << B) : sq_root[s];
      end
    end
  end

  // Setup: dividend = mag * 2^FRAC_BITS + r, divisor 2r, overflow when the
  // quotient needs more than Q_W bits.
  logic [DEN_W-1:0]       den0;
  logic [2:0][DIVD_W-1:0] divd0;
  logic [2:0]             ovf0;
  always_comb begin
    den0 = {sq_root[ROOT_W], 1'b0};
    for (int n = 0; n < 3; n++) begin
      divd0[n] = DIVD_W'({sq_side[ROOT_W].mag[n], {FRAC_BITS{1'b0}}})
               + DIVD_W'(sq_root[ROOT_W]);
      ovf0[n]  = DV_W'(divd0[n]) >= (DV_W'(den0) << Q_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side[0] <= sq_side[ROOT_W];
      dv_root[0] <= sq_root[ROOT_W];
      dv_ovf[0]  <= ovf0;
      dv_rem[0]  <= divd0;
      dv_quo[0]  <= '0;
    end
  end

  for (genvar t = 0; t < Q_W; t++) begin : g_dv
    localparam int B = Q_W - 1 - t;
    logic [DV_W-1:0]        sub;
    logic [2:0][DIVD_W-1:0] rem_d;
    logic [2:0][Q_W-1:0]    quo_d;
    always_comb begin
      sub = DV_W'({dv_root[t], 1'b0}) << B;
      for (int n = 0; n < 3; n++) begin
        if (DV_W'(dv_rem[t][n]) >= sub) begin
          rem_d[n] = dv_rem[t][n] - sub[DIVD_W-1:0];
          quo_d[n] = dv_quo[t][n] | (Q_W'(1) << B);
        end else begin
          rem_d[n] = dv_rem[t][n];
          quo_d[n] = dv_quo[t][n];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[t+1] <= 1'b0;
      end else if (en) begin
        dv_v[t+1] <= dv_v[t];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_side[t+1] <= dv_side[t];
        dv_root[t+1] <= dv_root[t];
        dv_ovf[t+1]  <= dv_ovf[t];
        dv_rem[t+1]  <= rem_d;
        dv_quo[t+1]  <= quo_d;
      end
    end
  end

  // Saturation, sign and placement of the root term.
  logic signed [FIELD_W-1:0] comp [3];
  logic signed [FIELD_W-1:0] lead_val;
  logic signed [FIELD_W-1:0] x_d, y_d, z_d, w_d;
  side_t                     fs;
  always_comb begin
    fs = dv_side[Q_W];
    for (int n = 0; n < 3; n++) begin
      if (fs.neg[n]) begin
        if (dv_ovf[Q_W][n] || dv_quo[Q_W][n] > Q_W'(262144)) begin
          comp[n] = FIELD_MIN;
        end else begin
          comp[n] = FIELD_W'(-$signed({1'b0, dv_quo[Q_W][n]}));
        end
      end else begin
        if (dv_ovf[Q_W][n] || dv_quo[Q_W][n] > Q_W'(FIELD_MAX)) begin
          comp[n] = FIELD_MAX;
        end else begin
          comp[n] = FIELD_W'(dv_quo[Q_W][n]);
        end
      end
    end
    lead_val = FIELD_W'((ROOT_W+1)'(dv_root[Q_W]) + 1'b1 >> 1);
    unique case (fs.lead)
      LEAD_X:  begin x_d = lead_val; y_d = comp[0];  z_d = comp[1];  w_d = comp[2];  end
      LEAD_Y:  begin x_d = comp[0];  y_d = lead_val; z_d = comp[1];  w_d = comp[2];  end
      LEAD_Z:  begin x_d = comp[0];  y_d = comp[1];  z_d = lead_val; w_d = comp[2];  end
      default: begin x_d = comp[0];  y_d = comp[1];  z_d = comp[2];  w_d = lead_val; end
    endcase
    if (fs.bad) begin
      x_d = '0;
      y_d = '0;
      z_d = '0;
      w_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= x_d;
      out_y_q   <= y_d;
      out_z_q   <= z_d;
      out_w_q   <= w_d;
      out_bad_q <= fs.bad;
    end
  end

  assign valid_o     = out_v_q;
  assign quat_x_o    = out_x_q;
  assign quat_y_o    = out_y_q;
  assign quat_z_o    = out_z_q;
  assign quat_w_o    = out_w_q;
  assign bad_input_o = out_bad_q;

endmodule

// ===== rtl/core/matrix_to_quaternion.sv =====
// Rotation matrix to quaternion converter, signed Q3.16 throughout.
// Input channel: valid_i / ready_o with the nine rotation elements e00..e22
// and the corner element e33; a beat is taken when both are high.
// Output channel: valid_o / ready_i with quat_x/y/z/w and bad_input; a beat
// leaves when both are high. bad_input is set, with all components zero,
// when the square root argument is not positive.
// The back pipeline runs through the 18-stage square root and the 20-stage
// divider, one result bit per stage.
// Throughput: one matrix per cycle while the receiver keeps ready_i high.
// A front stage classifies each beat (trace test, leading axis, numerators)
// and writes it to a four-entry queue; the back pipeline drains the queue.
// If the receiver stalls, the back pipeline freezes while the front keeps
// taking beats until the queue fills, then ready_o falls.
// Reset empties the queue and clears every valid bit; no results are held.
`timescale 1ns / 1ps
module matrix_to_quaternion (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e00_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e01_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e02_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e10_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e11_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e12_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e20_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e21_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e22_i,
  input  logic signed [m2q_pkg::FIELD_W-1:0]  e33_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_x_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_y_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_z_o,
  output logic signed [m2q_pkg::FIELD_W-1:0]  quat_w_o,
  output logic                                bad_input_o
);
  import m2q_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  // Front: classification registered once per beat.
  m2q_front u_front (
    .clk_i, .rst_ni,
    .valid_i, .ready_o,
    .e00_i, .e01_i, .e02_i, .e10_i, .e11_i, .e12_i,
    .e20_i, .e21_i, .e22_i, .e33_i,
    .valid_o(f_valid), .ready_i(f_ready), .item_o(f_item)
  );

  // Queue decoupling the front from the arithmetic pipeline.
  m2q_fifo u_fifo (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .item_i(f_item),
    .valid_o(q_valid), .ready_i(q_ready), .item_o(q_item)
  );

  // Back: root, divisions, saturation and the output register.
  m2q_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .item_i(q_item),
    .valid_o, .ready_i,
    .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o, .bad_input_o
  );

endmodule

// ===== dv/matrix_to_quaternion_test.sv =====
`timescale 1ns / 1ps
module matrix_to_quaternion_test;
  import m2q_pkg::*;

  typedef logic signed [FIELD_W-1:0] fix_t;

  typedef struct {
    fix_t e [10];
  } mat_t;

  typedef struct {
    fix_t x, y, z, w;
    logic bad;
  } quat_t;

  typedef struct {
    mat_t m;
    logic typed;
    quat_t q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  fix_t e_drv [10];
  logic ready_o, valid_o, bad_input_o;
  fix_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t pending_quats [$];
  int n_errors = 0;
  int n_results = 0;
  int n_bad = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  always #5 clk_i = ~clk_i;

  matrix_to_quaternion i_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .e00_i(e_drv[0]), .e01_i(e_drv[1]), .e02_i(e_drv[2]),
    .e10_i(e_drv[3]), .e11_i(e_drv[4]), .e12_i(e_drv[5]),
    .e20_i(e_drv[6]), .e21_i(e_drv[7]), .e22_i(e_drv[8]),
    .e33_i(e_drv[9]),
    .valid_o, .ready_i,
    .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o, .bad_input_o
  );

  function automatic longint clamp19(longint v);
    if (v > longint'(FIELD_MAX)) return longint'(FIELD_MAX);
    if (v < longint'(FIELD_MIN)) return longint'(FIELD_MIN);
    return v;
  endfunction

  function automatic longint floor_root(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Numerator scaled by one and divided by twice the root, ties away from zero.
  function automatic longint scaled_quotient(longint num, longint root);
    longint den, mag, quo;
    den = root * 2;
    mag = (num < 0) ? -num : num;
    quo = ((mag <<< FRAC_BITS) + den / 2) / den;
    return clamp19((num < 0) ? -quo : quo);
  endfunction

  function automatic quat_t predict_quat(mat_t m);
    longint d [3][3];
    longint c [4];
    longint unity, trace, arg, root;
    int lead, nj, nk;
    quat_t q;
    unity = longint'(1) <<< FRAC_BITS;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        d[a][b] = longint'(m.e[a*3+b]);
    trace = d[0][0] + d[1][1] + d[2][2] + longint'(m.e[9]);
    q.bad = 1'b0;
    if (trace >= unity) begin
      root = floor_root(trace <<< FRAC_BITS);
      c[0] = scaled_quotient(d[1][2] - d[2][1], root);
      c[1] = scaled_quotient(d[2][0] - d[0][2], root);
      c[2] = scaled_quotient(d[0][1] - d[1][0], root);
      c[3] = clamp19((root + 1) >>> 1);
    end else begin
      lead = (d[0][0] <= d[1][1]) ? 1 : 0;
      if (d[2][2] > d[lead][lead]) lead = 2;
      nj = (lead + 1) % 3;
      nk = (nj + 1) % 3;
      arg = d[lead][lead] - d[nj][nj] - d[nk][nk] + unity;
      if (arg <= 0) begin
        q.bad = 1'b1;
        c = '{0, 0, 0, 0};
      end else begin
        root = floor_root(arg <<< FRAC_BITS);
        c[lead] = clamp19((root + 1) >>> 1);
        c[nj] = scaled_quotient(d[nj][lead] + d[lead][nj], root);
        c[nk] = scaled_quotient(d[nk][lead] + d[lead][nk], root);
        c[3] = scaled_quotient(d[nj][nk] - d[nk][nj], root);
      end
    end
    q.x = fix_t'(c[0]);
    q.y = fix_t'(c[1]);
    q.z = fix_t'(c[2]);
    q.w = fix_t'(c[3]);
    return q;
  endfunction

  function automatic mat_t diag_mat(int a, int b, int c, int w);
    mat_t m;
    foreach (m.e[n]) m.e[n] = '0;
    m.e[0] = fix_t'(a);
    m.e[4] = fix_t'(b);
    m.e[8] = fix_t'(c);
    m.e[9] = fix_t'(w);
    return m;
  endfunction

  function automatic mat_t fill_mat(int v);
    mat_t m;
    foreach (m.e[n]) m.e[n] = fix_t'(v);
    return m;
  endfunction

  // Mostly near-rotation content so that every branch is reached, with noise mixed in.
  function automatic mat_t random_mat();
    mat_t m;
    int mode;
    mode = $urandom_range(0, 9);
    foreach (m.e[n]) begin
      if (mode < 3) m.e[n] = fix_t'($urandom);
      else m.e[n] = fix_t'($signed($urandom_range(0, 131072)) - 65536);
    end
    if (mode == 3 || mode == 4) begin
      m.e[$urandom_range(0, 2) * 4] = fix_t'($urandom_range(40000, 65536));
      m.e[9] = fix_t'(65536);
    end else if (mode >= 5) begin
      m.e[9] = fix_t'(65536);
    end
    return m;
  endfunction

  // Valid stays high between back-to-back beats and only drops for idle cycles.
  task automatic offer_beat(mat_t m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    foreach (e_drv[n]) e_drv[n] <= m.e[n];
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    pending_quats.push_back(predict_quat(m));
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, fix_t want, fix_t got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off counted in its own loop.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      ready_i <= 1'b0;
    end else begin
      ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && valid_o && ready_i) begin
      n_results++;
      if (pending_quats.size() == 0) begin
        $error("result beat arrived with nothing outstanding");
        n_errors++;
      end else begin
        want = pending_quats.pop_front();
        check_field("quat_x", want.x, quat_x_o);
        check_field("quat_y", want.y, quat_y_o);
        check_field("quat_z", want.z, quat_z_o);
        check_field("quat_w", want.w, quat_w_o);
        if (want.bad !== bad_input_o) begin
          $error("bad_input expected %0b got %0b", want.bad, bad_input_o);
          n_errors++;
        end
        if (want.bad) n_bad++;
      end
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t r;
    quat_t q;
    foreach (e_drv[n]) e_drv[n] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity: trace path, w is exactly one.
    q = '{x: 0, y: 0, z: 0, w: 19'sd65536, bad: 1'b0};
    rows.push_back('{diag_mat(65536, 65536, 65536, 65536), 1'b1, q});
    // Equal unit diagonal with a very negative corner: root argument is zero, flagged.
    q = '{x: 0, y: 0, z: 0, w: 0, bad: 1'b1};
    rows.push_back('{diag_mat(65536, 65536, 65536, -262144), 1'b1, q});
    rows.push_back('{fill_mat(-262144), 1'b0, q});
    // Half turns about each axis pick each leading component.
    q = '{x: 19'sd65536, y: 0, z: 0, w: 0, bad: 1'b0};
    rows.push_back('{diag_mat(65536, -65536, -65536, 65536), 1'b1, q});
    q = '{x: 0, y: 19'sd65536, z: 0, w: 0, bad: 1'b0};
    rows.push_back('{diag_mat(-65536, 65536, -65536, 65536), 1'b1, q});
    q = '{x: 0, y: 0, z: 19'sd65536, w: 0, bad: 1'b0};
    rows.push_back('{diag_mat(-65536, -65536, 65536, 65536), 1'b1, q});
    // Ties on the diagonal, extremes and the exact trace boundary.
    rows.push_back('{diag_mat(0, 0, 0, 65536), 1'b0, q});
    rows.push_back('{diag_mat(0, 0, 0, 65535), 1'b0, q});
    rows.push_back('{diag_mat(5, 5, 5, 0), 1'b0, q});
    rows.push_back('{fill_mat(0), 1'b0, q});
    rows.push_back('{diag_mat(262143, 262143, 262143, 262143), 1'b0, q});
    rows.push_back('{diag_mat(262143, -262144, -262144, -262144), 1'b0, q});
    rows.push_back('{diag_mat(-262144, -262144, 262143, -262144), 1'b0, q});
    rows.push_back('{fill_mat(262143), 1'b0, q});
    rows.push_back('{fill_mat(-1), 1'b0, q});
    r.m = diag_mat(1, 1, 1, 65533);
    r.m.e[1] = 19'sd262143; r.m.e[3] = -19'sd262144;
    r.m.e[5] = -19'sd262144; r.m.e[7] = 19'sd262143;
    r.m.e[2] = 19'sd262143; r.m.e[6] = -19'sd262144;
    r.typed = 1'b0;
    rows.push_back(r);
    r.m = diag_mat(65536, -262144, -262144, -262144);
    r.m.e[1] = 19'sd262143; r.m.e[3] = 19'sd262143;
    rows.push_back(r);

    foreach (rows[n]) begin
      if (rows[n].typed) begin
        q = predict_quat(rows[n].m);
        if (q != rows[n].q) begin
          $error("row %0d: predictor disagrees with typed value", n);
          n_errors++;
        end
      end
      offer_beat(rows[n].m);
    end
    drain_results();

    // Random phases with different idling patterns.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 64 : 25) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 64 : 25) : 0;
      repeat (80) offer_beat(random_mat());
      if (phase == 1) begin
        // Sender pauses until everything has come back.
        drain_results();
        send_idle_pct = 0;
        // Long hold-off at the receiver fills the block and stalls its input.
        @(posedge clk_i);
        hold_off_cycles <= 200;
        repeat (80) offer_beat(random_mat());
      end
    end
    drain_results();
    repeat (60) @(posedge clk_i);

    $display("Converted %0d matrices through all branches, %0d flagged bad.", n_results, n_bad);
    $display("Idling covered free-running, sender gaps, receiver stalls and a long hold-off.");
    if (n_errors == 0 && pending_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
